@@ src/cip_pkg.sv @@
// cip_pkg: shared types, constants and lookup tables for the canopy
// interception partition block. No dependencies.
package cip_pkg;

	// input word
	typedef struct packed {
		logic [2:0]  land_class;
		logic        urban_point;
		logic        wall_column;
		logic        vegetation_exposed;
		logic [31:0] rain_rate;
		logic [31:0] snow_rate;
		logic [15:0] leaf_area_index;
		logic [15:0] stem_area_index;
		logic [31:0] canopy_water_in;
	} item_t;

	// result word
	typedef struct packed {
		logic [31:0] canopy_water_out;
		logic [31:0] drip_rate;
		logic [31:0] snow_throughfall;
		logic [31:0] rain_throughfall;
		logic [31:0] intercepted_rate;
		logic [15:0] snow_fraction;
		logic [15:0] rain_fraction;
	} result_t;

	// column handling decided by the front end
	typedef enum logic [1:0] {
		KIND_PASS,    // canopy water unchanged, flows zero
		KIND_CLEAR,   // ice: canopy water cleared
		KIND_ACTIVE   // full interception computation
	} kind_t;

	// classified word queued between front and back
	typedef struct packed {
		kind_t       kind;
		logic [31:0] rain;
		logic [31:0] snow;
		logic [16:0] s;     // leaf + stem area index, Q5.12
		logic [31:0] cw;
	} work_t;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 17;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DEW   = 1'b0,
		REG_TIME_STEP = 1'b1
	} cfg_reg_t;
	localparam logic [15:0] MAX_DEW_RESET = 16'd6554;
	localparam logic [16:0] TIME_STEP_RESET = 17'd1800;

	// land classes
	localparam logic [2:0] LC_LAST_VEG = 3'd2;
	localparam logic [2:0] LC_ICE = 3'd3;
	localparam logic [2:0] LC_MULTI_ICE = 3'd4;

	// queue depth
	localparam int QUEUE_DEPTH = 4;

	// back-end stage map
	localparam int FRAC_STEPS = 17;
	localparam int DRIP_STEPS = 32;
	localparam int EXP_LOOKUP = 1;
	localparam int EXP_INTERP = 2;
	localparam int EXP_SCALE = 3;
	localparam int SPLIT = 4;
	localparam int STORE = 5;
	localparam int DRIP_SETUP = 6;
	localparam int FRAC_FIRST = 1;
	localparam int FRAC_LAST = FRAC_FIRST + FRAC_STEPS - 1;
	localparam int DRIP_FIRST = DRIP_SETUP + 1;
	localparam int DRIP_LAST = DRIP_FIRST + DRIP_STEPS - 1;
	localparam int LAST_STAGE = DRIP_LAST;

	// exp(-n) in Q0.16, zero from n = 12 on
	function automatic logic [16:0] exp_int(input logic [4:0] n);
		logic [16:0] v;
		unique case (n)
			5'd0: v = 17'd65536;
			5'd1: v = 17'd24109;
			5'd2: v = 17'd8869;
			5'd3: v = 17'd3263;
			5'd4: v = 17'd1200;
			5'd5: v = 17'd442;
			5'd6: v = 17'd162;
			5'd7: v = 17'd60;
			5'd8: v = 17'd22;
			5'd9: v = 17'd8;
			5'd10: v = 17'd3;
			5'd11: v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// exp(-j/16) in Q0.16, j = 0..16
	function automatic logic [16:0] exp_frac(input logic [4:0] j);
		logic [16:0] v;
		unique case (j)
			5'd0: v = 17'd65536;
			5'd1: v = 17'd61565;
			5'd2: v = 17'd57835;
			5'd3: v = 17'd54331;
			5'd4: v = 17'd51039;
			5'd5: v = 17'd47947;
			5'd6: v = 17'd45042;
			5'd7: v = 17'd42313;
			5'd8: v = 17'd39750;
			5'd9: v = 17'd37341;
			5'd10: v = 17'd35079;
			5'd11: v = 17'd32954;
			5'd12: v = 17'd30957;
			5'd13: v = 17'd29081;
			5'd14: v = 17'd27319;
			5'd15: v = 17'd25664;
			default: v = 17'd24109;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] sat32(input logic [32:0] v);
		return v[32] ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

@@ src/cip_front.sv @@
// cip_front: accepts input words, classifies each column and hands the
// classified word to the queue. Depends on cip_pkg.
module cip_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  cip_pkg::item_t  item,
	input  logic            q_full,
	output logic            q_push,
	output cip_pkg::work_t  q_word
);

	cip_pkg::work_t word_next;
	cip_pkg::work_t word_s1;
	logic           valid_s1;
	logic           load;
	logic           veg;
	logic [32:0]    total;

	// classification
	always_comb begin
		veg = (item.land_class <= cip_pkg::LC_LAST_VEG) || item.urban_point;
		total = {1'b0, item.rain_rate} + {1'b0, item.snow_rate};
		word_next.rain = item.rain_rate;
		word_next.snow = item.snow_rate;
		word_next.cw = item.canopy_water_in;
		word_next.s = {1'b0, item.leaf_area_index} + {1'b0, item.stem_area_index};
		if (veg) begin
			if (!item.wall_column && item.vegetation_exposed && (total != '0))
				word_next.kind = cip_pkg::KIND_ACTIVE;
			else
				word_next.kind = cip_pkg::KIND_PASS;
		end else if (item.land_class == cip_pkg::LC_ICE
				|| item.land_class == cip_pkg::LC_MULTI_ICE) begin
			word_next.kind = cip_pkg::KIND_CLEAR;
		end else begin
			word_next.kind = cip_pkg::KIND_PASS;
		end
	end

	// hold while the queue is full
	assign item_stall = valid_s1 && q_full;
	assign load = !item_stall;
	assign q_push = valid_s1 && !q_full;
	assign q_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (load && item_valid)
			word_s1 <= word_next;
	end

endmodule

@@ src/cip_queue.sv @@
// cip_queue: short FIFO of classified words between front and back.
// Depends on cip_pkg.
module cip_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cip_pkg::work_t  push_word,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output cip_pkg::work_t  pop_word
);

	localparam int PTR_W = $clog2(cip_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(cip_pkg::QUEUE_DEPTH + 1);

	cip_pkg::work_t   mem_q [cip_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_W'(cip_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_word = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(cip_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(cip_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_word;
	end

endmodule

@@ src/cip_back.sv @@
// cip_back: configuration registers and the arithmetic pipeline: exp
// lookup, split, canopy store, fraction and drip dividers, output word.
// Depends on cip_pkg.
module cip_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [cip_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cip_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             q_empty,
	input  cip_pkg::work_t                   q_word,
	output logic                             q_pop,
	output logic                             result_valid,
	input  logic                             result_stall,
	output cip_pkg::result_t                 result
);

	typedef struct packed {
		cip_pkg::kind_t kind;
		logic [31:0] rain;
		logic [31:0] snow;
		logic [16:0] s;
		logic [31:0] cw;
		logic [32:0] tot;
		logic [33:0] fs_rem;
		logic [16:0] fs_q;
		logic [33:0] fr_rem;
		logic [16:0] fr_q;
		logic [23:0] prod;
		logic [16:0] f;
		logic [14:0] fpi;
		logic [31:0] thr_s;
		logic [31:0] thr_r;
		logic [31:0] intr;
		logic [29:0] cap;
		logic [41:0] water;
		logic        gt;
		logic        dsat;
		logic [17:0] d_rem;
		logic [31:0] d_low;
		logic [31:0] d_q;
	} ctx_t;

	localparam int NST = cip_pkg::LAST_STAGE + 1;

	logic [15:0]      dew_q;
	logic [16:0]      dt_q;
	logic [16:0]      dt;
	logic             en;
	ctx_t             pipe_q [NST];
	logic [NST-1:0]   valid_q;
	cip_pkg::result_t res_next;

	// load a classified word into the pipeline
	function automatic ctx_t load_ctx(input cip_pkg::work_t w);
		ctx_t o;
		o = '0;
		o.kind = w.kind;
		o.rain = w.rain;
		o.snow = w.snow;
		o.s = w.s;
		o.cw = w.cw;
		o.tot = {1'b0, w.rain} + {1'b0, w.snow};
		o.fs_rem = {2'b0, w.snow};
		o.fr_rem = {2'b0, w.rain};
		return o;
	endfunction

	// work done in stage k
	function automatic ctx_t stage_step(input int k, input ctx_t c,
			input logic [16:0] tstep, input logic [15:0] dew);
		ctx_t        o;
		logic [16:0] hi;
		logic [16:0] lo;
		logic [15:0] diff;
		logic [24:0] rnd;
		logic [33:0] pe;
		logic [16:0] e;
		logic [16:0] fpi_t;
		logic [16:0] omf;
		logic [48:0] m_s;
		logic [48:0] m_r;
		logic [48:0] m_i;
		logic [32:0] cap_p;
		logic [49:0] m_w;
		logic [49:0] dvd;
		logic [49:0] lim;
		logic [17:0] t18;
		logic [33:0] tot34;
		o = c;
		tot34 = {1'b0, c.tot};
		// fraction dividers, one quotient bit a stage
		if (k >= cip_pkg::FRAC_FIRST && k <= cip_pkg::FRAC_LAST) begin
			if (c.fs_rem >= tot34) begin
				o.fs_rem = c.fs_rem - tot34;
				o.fs_q = {c.fs_q[15:0], 1'b1};
			end else begin
				o.fs_q = {c.fs_q[15:0], 1'b0};
			end
			o.fs_rem = {o.fs_rem[32:0], 1'b0};
			if (c.fr_rem >= tot34) begin
				o.fr_rem = c.fr_rem - tot34;
				o.fr_q = {c.fr_q[15:0], 1'b1};
			end else begin
				o.fr_q = {c.fr_q[15:0], 1'b0};
			end
			o.fr_rem = {o.fr_rem[32:0], 1'b0};
		end
		// exp table slope times interpolation bits
		if (k == cip_pkg::EXP_LOOKUP) begin
			hi = cip_pkg::exp_frac({1'b0, c.s[11:8]});
			lo = cip_pkg::exp_frac({1'b0, c.s[11:8]} + 5'd1);
			diff = 16'(hi - lo);
			o.prod = diff * c.s[7:0];
		end
		// interpolated fraction part
		if (k == cip_pkg::EXP_INTERP) begin
			hi = cip_pkg::exp_frac({1'b0, c.s[11:8]});
			rnd = {1'b0, c.prod} + 25'd128;
			o.f = hi - rnd[24:8];
		end
		// scale by integer part, interception fraction
		if (k == cip_pkg::EXP_SCALE) begin
			pe = cip_pkg::exp_int(c.s[16:12]) * c.f + 34'd32768;
			e = pe[32:16];
			fpi_t = 17'd65538 - e;
			o.fpi = fpi_t[16:2];
		end
		// throughfall, interception, capacity
		if (k == cip_pkg::SPLIT) begin
			omf = 17'd65536 - {2'b0, c.fpi};
			m_s = c.snow * omf + 49'd32768;
			m_r = c.rain * omf + 49'd32768;
			m_i = c.tot * c.fpi + 49'd32768;
			o.thr_s = cip_pkg::sat32(m_s[48:16]);
			o.thr_r = cip_pkg::sat32(m_r[48:16]);
			o.intr = cip_pkg::sat32(m_i[48:16]);
			cap_p = dew * c.s;
			o.cap = cap_p[32:3];
		end
		// add the step's intercepted water
		if (k == cip_pkg::STORE) begin
			m_w = c.intr * tstep + 50'd128;
			o.water = m_w[49:8] + {10'b0, c.cw};
		end
		// excess over capacity, drip dividend and overflow check
		if (k == cip_pkg::DRIP_SETUP) begin
			o.gt = c.water > {12'b0, c.cap};
			dvd = {c.water - {12'b0, c.cap}, 8'b0};
			lim = {1'b0, tstep, 32'b0};
			o.dsat = dvd >= lim;
			o.d_rem = dvd[49:32];
			o.d_low = dvd[31:0];
			o.d_q = '0;
		end
		// drip divider, one quotient bit a stage
		if (k >= cip_pkg::DRIP_FIRST && k <= cip_pkg::DRIP_LAST) begin
			t18 = {c.d_rem[16:0], c.d_low[31]};
			if (t18 >= {1'b0, tstep}) begin
				o.d_rem = t18 - {1'b0, tstep};
				o.d_q = {c.d_q[30:0], 1'b1};
			end else begin
				o.d_rem = t18;
				o.d_q = {c.d_q[30:0], 1'b0};
			end
			o.d_low = {c.d_low[30:0], 1'b0};
		end
		return o;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dew_q <= cip_pkg::MAX_DEW_RESET;
			dt_q <= cip_pkg::TIME_STEP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cip_pkg::REG_MAX_DEW: dew_q <= cfg_data[15:0];
				cip_pkg::REG_TIME_STEP: dt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero time step counts as one second
	assign dt = (dt_q == '0) ? 17'd1 : dt_q;

	// whole pipeline moves when the output register can take a word
	assign en = !result_valid || !result_stall;
	assign q_pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			result_valid <= 1'b0;
		end else if (en) begin
			valid_q <= {valid_q[NST-2:0], !q_empty};
			result_valid <= valid_q[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			pipe_q[0] <= load_ctx(q_word);
	end

	for (genvar k = 1; k < NST; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en)
				pipe_q[k] <= stage_step(k, pipe_q[k-1], dt, dew_q);
		end
	end

	// output word
	always_comb begin
		res_next = '0;
		unique case (pipe_q[NST-1].kind)
			cip_pkg::KIND_ACTIVE: begin
				if (pipe_q[NST-1].gt) begin
					res_next.canopy_water_out = {2'b0, pipe_q[NST-1].cap};
					res_next.drip_rate = pipe_q[NST-1].dsat ? 32'hFFFF_FFFF
						: pipe_q[NST-1].d_q;
				end else begin
					res_next.canopy_water_out = (pipe_q[NST-1].water[41:32] != '0)
						? 32'hFFFF_FFFF : pipe_q[NST-1].water[31:0];
				end
				res_next.snow_throughfall = pipe_q[NST-1].thr_s;
				res_next.rain_throughfall = pipe_q[NST-1].thr_r;
				res_next.intercepted_rate = pipe_q[NST-1].intr;
				res_next.snow_fraction = pipe_q[NST-1].fs_q[16] ? 16'hFFFF
					: pipe_q[NST-1].fs_q[15:0];
				res_next.rain_fraction = pipe_q[NST-1].fr_q[16] ? 16'hFFFF
					: pipe_q[NST-1].fr_q[15:0];
			end
			cip_pkg::KIND_CLEAR: res_next.canopy_water_out = '0;
			default: res_next.canopy_water_out = pipe_q[NST-1].cw;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			result <= res_next;
	end

endmodule

@@ src/canopy_interception_partition.sv @@
// canopy_interception_partition: top level; front end, queue and back end.
// Depends on cip_pkg, cip_front, cip_queue, cip_back.
//
// Usage:
//  - item channel: one land column per word, taken when item_valid is high
//    and item_stall is low. One result word per item on the result channel,
//    taken when result_valid is high and result_stall is low.
//  - cfg channel: cfg_index 0 writes max_dew_per_area, 1 writes
//    time_step_seconds; cfg_ready is always high. Write only while idle.
//  - Throughput: one column per cycle while result_stall is low, set by the
//    fully pipelined arithmetic back end (one quotient bit per stage in the
//    fraction and drip dividers).
//  - Path: after the front register takes the word, it passes through the
//    queue, 39 back stages and the output register before result valid.
//  - The 32-stage drip divider makes up most of the back stages.
//  - When the receiver stalls, the back pipeline holds; the 4-word queue
//    and the front register keep absorbing items until full, then
//    item_stall rises.
//  - Reset clears the pipeline and queue and loads the register defaults
//    (6554 and 1800).
module canopy_interception_partition (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  cip_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output cip_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cip_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cip_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	cip_pkg::work_t q_in;
	cip_pkg::work_t q_out;

	assign cfg_ready = 1'b1;

	cip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_word     (q_in)
	);

	cip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_word  (q_out)
	);

	cip_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_empty      (q_empty),
		.q_word       (q_out),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ src/cip_checker.sv @@
// cip_checker: port-level assertions for the top level, attached by bind.
// Depends on cip_pkg and canopy_interception_partition.
module cip_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input cip_pkg::result_t result
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	// a stalled result keeps its payload
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	// floored fractions never sum above one
	a_frac_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, result.snow_fraction} + {1'b0, result.rain_fraction}
			<= 17'd65536))
		else $error("snow and rain fractions exceed one");

	// drip only comes from a column with precipitation
	a_drip_precip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.drip_rate != '0)
			|-> (result.snow_fraction != '0) || (result.rain_fraction != '0))
		else $error("drip without precipitation");

endmodule

bind canopy_interception_partition cip_checker u_cip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
